[rtl/clook_pkg.sv]
// ----------------------------------------------------------------------------
// C-LOOK scheduler package
// Shared widths, codes and word types of the C-LOOK disk scheduler.
// ----------------------------------------------------------------------------
package clook_pkg;

  localparam int unsigned MAX_REQUESTS_DEF = 32;
  localparam int unsigned TRACK_W          = 16;
  localparam int unsigned TCOUNT_W         = 17;
  localparam int unsigned TOTAL_W          = 22;
  localparam int unsigned REQTOT_W         = 6;
  localparam int unsigned APB_AW           = 3;
  localparam int unsigned APB_DW           = 32;

  localparam logic [TCOUNT_W-1:0] TRACK_COUNT_RESET = 17'h10000;

  // Word index of the track count register (byte address 0).
  localparam logic REG_TRACK_COUNT = 1'b0;

  typedef enum logic [1:0] {
    STATUS_MOVE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic               func;
    logic [TRACK_W-1:0] track;
    logic               batch_end;
  } in_word_t;

  typedef struct packed {
    status_e             status;
    logic [TRACK_W-1:0]  from_track;
    logic [TRACK_W-1:0]  to_track;
    logic [TRACK_W-1:0]  seek;
    logic [TOTAL_W-1:0]  total_seek;
    logic [REQTOT_W-1:0] request_total;
    logic                final_res;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [TRACK_W-1:0] val;
  } cell_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [TRACK_W-1:0] data;
    logic               recycle;
  } cell_ctrl_t;

endpackage

[rtl/clook_disk_scheduler.sv]
// ----------------------------------------------------------------------------
// C-LOOK disk scheduler
// Collects a head track and a batch of requests, then issues C-LOOK moves.
// ----------------------------------------------------------------------------
// Words with func 0 set the head track and words with func 1 add a request;
// each input word is taken while the block loads and the output register is free,
// and a request is sorted into a chain of MAX_REQUESTS cells in the same cycle.
// A word whose track is not below track_count, or a request that finds the
// chain full, is dropped and answered with a status word. The word that
// carries batch_end starts the schedule: with m stored requests of which k lie
// below the head, the chain first rotates those k requests to its tail, one
// cell shift per cycle, then issues the m moves at one per cycle as long as
// the consumer takes them, and new input words wait until the final move has
// been loaded. An empty batch gives a single status word. The final move
// carries the total seek and the head-plus-requests count. Track count is an
// APB register at byte address 0, reset to 65536.
module clook_disk_scheduler
  import clook_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_ROTATE = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_EMPTY  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [TCOUNT_W-1:0] tcount_q;
  logic [TRACK_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]    stored_q, stored_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TRACK_W-1:0]  prev_q, prev_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  cell_ctrl_t          ctrl;
  cell_t               chain [MAX_REQUESTS];

  logic                out_free, accept, out_of_range, full, insert;
  logic [CNT_W-1:0]    stored_inc;
  logic [TRACK_W-1:0]  seek;
  logic [TOTAL_W-1:0]  total_sum;
  logic                last_move;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRACK_COUNT) ? APB_DW'(tcount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q <= TRACK_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TRACK_COUNT)) begin
      tcount_q <= pwdata[TCOUNT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sorting chain. Cell 0 sees a valid zero on its left so that a new track
  // always lands there when the chain is empty or the track is the smallest.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    cell_t left, right;
    if (i == 0) begin : g_first
      assign left = '{valid: 1'b1, val: '0};
    end else begin : g_left
      assign left = chain[i-1];
    end
    if (i == MAX_REQUESTS - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = chain[i+1];
    end
    clook_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .cell_o  (chain[i])
    );
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == ST_LOAD) && out_free;
  assign accept       = in_valid_i && in_ready_o;
  assign out_of_range = {1'b0, in_word_i.track} >= tcount_q;
  assign full         = (stored_q == CNT_W'(MAX_REQUESTS));
  assign insert       = accept && !out_of_range && in_word_i.func && !full;
  assign stored_inc   = stored_q + CNT_W'(insert);

  // Moves within the upper or lower run go up; the wrap move goes down.
  assign seek      = (chain[0].val >= prev_q) ? (chain[0].val - prev_q)
                                              : (prev_q - chain[0].val);
  assign total_sum = total_q + TOTAL_W'(seek);
  assign last_move = (CNT_W'(cnt_q + 1'b1) == stored_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    stored_d    = stored_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl        = '{op: CELL_HOLD, data: in_word_i.track, recycle: 1'b0};

    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (out_of_range || (in_word_i.func && full)) begin
            out_valid_d         = 1'b1;
            out_d               = '0;
            out_d.status        = out_of_range ? STATUS_RANGE : STATUS_FULL;
            out_d.from_track    = in_word_i.track;
            out_d.to_track      = in_word_i.track;
          end else if (!in_word_i.func) begin
            head_d = in_word_i.track;
          end
          if (insert) begin
            ctrl.op = CELL_INSERT;
          end
          stored_d = stored_inc;
          if (in_word_i.batch_end) begin
            cnt_d   = '0;
            state_d = (stored_inc == '0) ? ST_EMPTY : ST_ROTATE;
          end
        end
      end
      ST_ROTATE: begin
        // Requests below the head go to the tail, in order.
        if ((cnt_q != stored_q) && (chain[0].val < head_q)) begin
          ctrl    = '{op: CELL_SHIFT, data: chain[0].val, recycle: 1'b1};
          cnt_d   = cnt_q + 1'b1;
        end else begin
          cnt_d   = '0;
          prev_d  = head_q;
          total_d = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctrl              = '{op: CELL_SHIFT, data: chain[0].val, recycle: 1'b0};
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.status      = STATUS_MOVE;
          out_d.from_track  = prev_q;
          out_d.to_track    = chain[0].val;
          out_d.seek        = seek;
          prev_d            = chain[0].val;
          total_d           = total_sum;
          cnt_d             = cnt_q + 1'b1;
          if (last_move) begin
            out_d.total_seek    = total_sum;
            out_d.request_total = REQTOT_W'(stored_q) + REQTOT_W'(1);
            out_d.final_res     = 1'b1;
            stored_d            = '0;
            state_d             = ST_LOAD;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.status        = STATUS_EMPTY;
          out_d.from_track    = head_q;
          out_d.to_track      = head_q;
          out_d.request_total = REQTOT_W'(1);
          out_d.final_res     = 1'b1;
          state_d             = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      head_q      <= '0;
      stored_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      stored_q    <= stored_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    total_q <= total_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stored_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CNT_W'(MAX_REQUESTS))
    else $error("stored request count exceeds the chain length");

  a_rotate_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROTATE) |-> (stored_q != '0) && chain[0].valid)
    else $error("rotation started on an empty chain");

  a_emit_cell_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> chain[0].valid)
    else $error("move issued from an empty cell");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && last_move)
      |=> (state_q == ST_LOAD) && (stored_q == '0) && out_word_o.final_res
          && !chain[0].valid)
    else $error("schedule did not drain the chain on its final move");

endmodule

[rtl/clook_cell.sv]
// ----------------------------------------------------------------------------
// C-LOOK sorting cell
// One slot of the sorted request chain: insertion by compare against the
// broadcast track, and a shift toward the head of the chain with recycling.
// ----------------------------------------------------------------------------
module clook_cell
  import clook_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_t      left_i,
  input  cell_t      right_i,
  output cell_t      cell_o
);

  logic               valid_q, valid_d;
  logic [TRACK_W-1:0] val_q, val_d;

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        // Entries at or below the new track stay; the rest move up one slot.
        if (!(valid_q && (val_q <= ctrl_i.data))) begin
          if (left_i.valid && (left_i.val > ctrl_i.data)) begin
            valid_d = 1'b1;
            val_d   = left_i.val;
          end else if (left_i.valid) begin
            valid_d = 1'b1;
            val_d   = ctrl_i.data;
          end
        end
      end
      CELL_SHIFT: begin
        // The current tail takes the recycled entry, if there is one.
        if (right_i.valid) begin
          valid_d = 1'b1;
          val_d   = right_i.val;
        end else if (valid_q) begin
          valid_d = ctrl_i.recycle;
          val_d   = ctrl_i.data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign cell_o = '{valid: valid_q, val: val_q};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// C-LOOK disk scheduler testbench
// Drives batches of head and request words into the scheduler and checks
// every result word against a C-LOOK predictor held in the testbench.
// ----------------------------------------------------------------------------
// The stimulus runs as a chain of test tasks: a directed pass over the
// schedule shapes, the track-count limit, the full request store, and then
// random traffic under several track counts. A single sender task owns the
// input channel and predicts each word as it is accepted. The result side
// runs in its own process, stalls at random, and compares each result word
// field by field with the oldest prediction.
module tb_top;
  import clook_pkg::*;

  localparam int unsigned MAX_REQ      = MAX_REQUESTS_DEF;
  localparam int unsigned LIMIT_CYCLES = 10_000_000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned END_WAIT     = 80;
  localparam int unsigned MAX_REPORTS  = 40;

  // Operation codes carried in the func field of an input word.
  localparam logic FUNC_HEAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_word;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Predictor state: the register copy, the head, the requests gathered in
  // the open batch and the result words that are still owed.
  logic [TCOUNT_W-1:0] track_limit = TRACK_COUNT_RESET;
  logic [TRACK_W-1:0]  head_pos = '0;
  logic [TRACK_W-1:0]  pending_reqs[$];
  out_word_t           owed_moves[$];

  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  bit          sender_idles = 1'b1;
  bit          reader_stalls = 1'b1;
  int unsigned stall_left = 0;

  clook_disk_scheduler dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // A hung handshake or a schedule that never finishes ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("clook_disk_scheduler regression: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  function automatic out_word_t status_word(status_e st, logic [TRACK_W-1:0] from_t,
                                            logic [TRACK_W-1:0] to_t,
                                            logic [TRACK_W-1:0] seek_len);
    out_word_t w;
    w               = '0;
    w.status        = st;
    w.from_track    = from_t;
    w.to_track      = to_t;
    w.seek          = seek_len;
    return w;
  endfunction

  // One head movement; the running total is kept for the final word. The
  // wrap move goes down, every other move goes up.
  task automatic add_move(input logic [TRACK_W-1:0] from_t, input logic [TRACK_W-1:0] to_t,
                          inout logic [TOTAL_W-1:0] total);
    logic [TRACK_W-1:0] seek_len;
    seek_len = (to_t >= from_t) ? (to_t - from_t) : (from_t - to_t);
    total    = total + TOTAL_W'(seek_len);
    owed_moves.push_back(status_word(STATUS_MOVE, from_t, to_t, seek_len));
  endtask

  // Sorts the head in with the stored requests and lays out the C-LOOK
  // sweep: up from the head, one jump down to the lowest track, then up
  // again until just below the head.
  task automatic schedule_batch();
    logic [TRACK_W-1:0] order[0:MAX_REQ];
    logic [TRACK_W-1:0] v;
    logic [TOTAL_W-1:0] total;
    out_word_t          w;
    int                 n;
    int                 i;
    int                 j;
    int                 pos;
    if (pending_reqs.size() == 0) begin
      w               = status_word(STATUS_EMPTY, head_pos, head_pos, '0);
      w.request_total = REQTOT_W'(1);
      w.final_res     = 1'b1;
      owed_moves.push_back(w);
      return;
    end
    n        = pending_reqs.size() + 1;
    order[0] = head_pos;
    for (i = 1; i < n; i++) order[i] = pending_reqs[i-1];
    for (i = 1; i < n; i++) begin
      v = order[i];
      j = i;
      while (j > 0 && order[j-1] > v) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    // With duplicates of the head, the first sorted copy is the start point.
    pos = -1;
    for (i = 0; i < n; i++) begin
      if (pos < 0 && order[i] == head_pos) pos = i;
    end
    total = '0;
    for (i = pos + 1; i < n; i++) add_move(order[i-1], order[i], total);
    if (pos > 0) add_move(order[n-1], order[0], total);
    for (i = 1; i < pos; i++) add_move(order[i-1], order[i], total);
    w               = owed_moves.pop_back();
    w.total_seek    = total;
    w.request_total = REQTOT_W'(n);
    w.final_res     = 1'b1;
    owed_moves.push_back(w);
  endtask

  // Applies one accepted input word to the predictor. The range check comes
  // before the full-store check, and a rejected word that ends the batch is
  // answered first and then scheduled.
  task automatic take_word(in_word_t w);
    if ({1'b0, w.track} >= track_limit) begin
      owed_moves.push_back(status_word(STATUS_RANGE, w.track, w.track, '0));
    end else if (w.func == FUNC_HEAD) begin
      head_pos = w.track;
    end else if (pending_reqs.size() >= MAX_REQ) begin
      owed_moves.push_back(status_word(STATUS_FULL, w.track, w.track, '0));
    end else begin
      pending_reqs.push_back(w.track);
    end
    if (w.batch_end) begin
      schedule_batch();
      pending_reqs.delete();
    end
  endtask

  // ------------------------------------------------------------------------
  // Result side: random stalls and the field-by-field check
  // ------------------------------------------------------------------------

  task automatic report_field(string name, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (owed_moves.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: unexpected result word, actual status %0d from %0d to %0d",
                 $time, got.status, got.from_track, got.to_track);
      return;
    end
    want = owed_moves.pop_front();
    if (got.status !== want.status)
      report_field("status", want.status, got.status);
    if (got.from_track !== want.from_track)
      report_field("from_track", want.from_track, got.from_track);
    if (got.to_track !== want.to_track)
      report_field("to_track", want.to_track, got.to_track);
    if (got.seek !== want.seek)
      report_field("seek", want.seek, got.seek);
    if (got.total_seek !== want.total_seek)
      report_field("total_seek", want.total_seek, got.total_seek);
    if (got.request_total !== want.request_total)
      report_field("request_total", want.request_total, got.request_total);
    if (got.final_res !== want.final_res)
      report_field("final_res", want.final_res, got.final_res);
  endtask

  // The ready line is sampled here before it changes, so the check sees the
  // same handshake the block saw. About one stall in ten is drawn from a
  // longer range than the rest.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_word);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (reader_stalls && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!sender_idles || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one word. Valid stays high from one word to the next when there
  // is no gap, so it is never dropped and raised in the same step.
  task automatic send_word(logic func, logic [TRACK_W-1:0] track, logic batch_end);
    int unsigned gap;
    in_word_t    w;
    w.func      = func;
    w.track     = track;
    w.batch_end = batch_end;
    gap         = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_word(w);
    words_sent++;
  endtask

  // Holds the input side until every owed result has come back, then lets
  // the block settle before anything else is written.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write of the track count, a setup phase and then an access phase; the
  // register takes the value at the edge that ends the access cycle.
  task automatic write_track_count(logic [TCOUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TRACK_COUNT, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    track_limit = value;
  endtask

  // Picks a track around the current limit: mostly legal tracks, some
  // clustered near a base to give duplicates, both edges of the legal
  // range, and a share that lands on or past the limit.
  function automatic logic [TRACK_W-1:0] pick_track(int unsigned base);
    int unsigned r;
    int unsigned lim;
    int unsigned v;
    r   = $urandom_range(0, 99);
    lim = track_limit;
    if (r < 10 || lim == 0) return TRACK_W'($urandom);
    if (r < 15) return TRACK_W'(lim);
    if (r < 25) return ($urandom_range(0, 1) != 0) ? TRACK_W'(0) : TRACK_W'(lim - 1);
    if (r < 50) begin
      v = (base % lim) + $urandom_range(0, 7);
      return (v >= lim) ? TRACK_W'(lim - 1) : TRACK_W'(v);
    end
    return TRACK_W'($urandom_range(0, lim - 1));
  endfunction

  // A well-formed batch is up to two heads, then requests, with batch_end on
  // the last word. A broken batch leaves off batch_end, so its requests pile
  // up into the next one and can overrun the store.
  task automatic send_batch(bit closed);
    int unsigned r;
    int unsigned nreq;
    int unsigned base;
    int unsigned i;
    base = $urandom;
    r    = $urandom_range(0, 99);
    if (r < 8)       nreq = 0;
    else if (r < 80) nreq = $urandom_range(1, 10);
    else if (r < 93) nreq = $urandom_range(11, MAX_REQ);
    else             nreq = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
    if ($urandom_range(0, 9) == 0) send_word(FUNC_HEAD, pick_track(base), 1'b0);
    if (nreq == 0) begin
      send_word(FUNC_HEAD, pick_track(base), closed);
      return;
    end
    if ($urandom_range(0, 9) != 0) send_word(FUNC_HEAD, pick_track(base), 1'b0);
    for (i = 0; i < nreq; i++)
      send_word(FUNC_REQUEST, pick_track(base), closed && (i == nreq - 1));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Sweep shapes at the reset track count: both edges of the track range,
  // an empty batch ended by a head word, several heads, duplicates of the
  // head, all requests above the head and all below it.
  task automatic test_schedule_shapes();
    send_word(FUNC_HEAD, 16'd100, 1'b0);
    send_word(FUNC_REQUEST, 16'd150, 1'b0);
    send_word(FUNC_REQUEST, 16'd50, 1'b0);
    send_word(FUNC_REQUEST, 16'd0, 1'b0);
    send_word(FUNC_REQUEST, 16'hFFFF, 1'b1);
    send_word(FUNC_HEAD, 16'hFFFF, 1'b1);
    send_word(FUNC_HEAD, 16'd10, 1'b0);
    send_word(FUNC_HEAD, 16'd20, 1'b0);
    send_word(FUNC_REQUEST, 16'd20, 1'b0);
    send_word(FUNC_REQUEST, 16'd20, 1'b0);
    send_word(FUNC_REQUEST, 16'd5, 1'b0);
    send_word(FUNC_REQUEST, 16'd30, 1'b1);
    send_word(FUNC_HEAD, 16'd0, 1'b0);
    send_word(FUNC_REQUEST, 16'd3, 1'b0);
    send_word(FUNC_REQUEST, 16'd1, 1'b1);
    send_word(FUNC_HEAD, 16'hFFFF, 1'b0);
    send_word(FUNC_REQUEST, 16'd7, 1'b0);
    send_word(FUNC_REQUEST, 16'd9, 1'b1);
    // The head is kept from the previous batch here.
    send_word(FUNC_REQUEST, 16'd42, 1'b1);
  endtask

  // Tracks on and past the limit, a rejected word that ends its batch, and
  // a zero track count under which every word is rejected.
  task automatic test_track_limit();
    wait_idle();
    write_track_count(17'd100);
    send_word(FUNC_HEAD, 16'd99, 1'b0);
    send_word(FUNC_REQUEST, 16'd99, 1'b0);
    send_word(FUNC_REQUEST, 16'd100, 1'b0);
    send_word(FUNC_HEAD, 16'd200, 1'b0);
    send_word(FUNC_REQUEST, 16'hFFFF, 1'b1);
    wait_idle();
    write_track_count(17'd1);
    send_word(FUNC_REQUEST, 16'd0, 1'b0);
    send_word(FUNC_HEAD, 16'd1, 1'b1);
    wait_idle();
    write_track_count(17'd0);
    send_word(FUNC_REQUEST, 16'd0, 1'b0);
    send_word(FUNC_HEAD, 16'd0, 1'b1);
    wait_idle();
    write_track_count(17'd65535);
    send_word(FUNC_REQUEST, 16'hFFFF, 1'b0);
    send_word(FUNC_REQUEST, 16'hFFFE, 1'b1);
  endtask

  // Fills the store exactly, overruns it with two more requests, the second of
  // which ends the batch, then runs one exactly full batch.
  task automatic test_store_full();
    int unsigned i;
    wait_idle();
    write_track_count(TRACK_COUNT_RESET);
    send_word(FUNC_HEAD, TRACK_W'($urandom), 1'b0);
    for (i = 0; i < MAX_REQ + 2; i++)
      send_word(FUNC_REQUEST, TRACK_W'($urandom), i == MAX_REQ + 1);
    for (i = 0; i < MAX_REQ; i++)
      send_word(FUNC_REQUEST, TRACK_W'($urandom), i == MAX_REQ - 1);
  endtask

  // Random batches and single words under one track count. Now and then the
  // sender holds off until every owed result is back.
  task automatic test_random_traffic(logic [TCOUNT_W-1:0] limit, int unsigned count);
    int unsigned start;
    int unsigned r;
    wait_idle();
    write_track_count(limit);
    start = words_sent;
    while (words_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 3) wait_idle();
      if (r < 78)      send_batch(1'b1);
      else if (r < 88) send_batch(1'b0);
      else send_word(logic'($urandom_range(0, 1)), pick_track($urandom),
                     $urandom_range(0, 9) < 3);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_schedule_shapes();
    test_track_limit();
    test_store_full();

    test_random_traffic(TRACK_COUNT_RESET, 100);
    test_random_traffic(17'd1000, 80);
    // A stretch with no idling on either side.
    sender_idles  = 1'b0;
    reader_stalls = 1'b0;
    test_random_traffic(17'd65535, 50);
    sender_idles  = 1'b1;
    reader_stalls = 1'b1;
    test_random_traffic(TCOUNT_W'($urandom_range(2, 65536)), 60);
    test_random_traffic(17'd1, 30);
    reader_stalls = 1'b0;
    test_random_traffic(17'd16, 50);
    reader_stalls = 1'b1;
    test_random_traffic(TRACK_COUNT_RESET, 50);

    // Let the last schedule drain, then watch a while for stray words.
    in_valid <= 1'b0;
    while (owed_moves.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (owed_moves.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d expected result words never arrived", $time, owed_moves.size());
    end

    if (mismatches == 0) begin
      $display("clook_disk_scheduler regression: pass");
    end else begin
      $display("clook_disk_scheduler regression: fail");
    end
    $finish;
  end

endmodule
